// File: rtl/pdlc_pkg.sv
// Types, codes and the microcode program of the combination lock controller.
// Used by password_door_lock_controller; depends on nothing else.
package pdlc_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] motor_drive;
    logic       buzzer_on;
    logic       last;
  } out_t;

  typedef enum logic [10:0] {
    PH_EN_WAIT1 = 11'b000_0000_0001,
    PH_EN_CODE1 = 11'b000_0000_0010,
    PH_EN_WAIT2 = 11'b000_0000_0100,
    PH_EN_CODE2 = 11'b000_0000_1000,
    PH_IDLE     = 11'b000_0001_0000,
    PH_CODE     = 11'b000_0010_0000,
    PH_CMD      = 11'b000_0100_0000,
    PH_RUN_CW   = 11'b000_1000_0000,
    PH_OPEN     = 11'b001_0000_0000,
    PH_RUN_CCW  = 11'b010_0000_0000,
    PH_ALARM    = 11'b100_0000_0000
  } phase_t;

  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_CW   = 2'd1;
  localparam logic [1:0] MOTOR_CCW  = 2'd2;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  // byte keys inside protocol_codes
  localparam logic [2:0] KEY_READY_SEND = 3'd0;
  localparam logic [2:0] KEY_READY_RECV = 3'd1;
  localparam logic [2:0] KEY_CHANGE     = 3'd2;
  localparam logic [2:0] KEY_UNLOCKING  = 3'd3;
  localparam logic [2:0] KEY_WRONG      = 3'd4;
  localparam logic [2:0] KEY_CHANGING   = 3'd5;
  localparam logic [2:0] KEY_MATCHED    = 3'd6;
  localparam logic [2:0] KEY_MISMATCHED = 3'd7;

  localparam logic [7:0] CHAR_PLUS = 8'h2B;

  // configuration register indexes
  localparam logic [2:0] REG_PROTOCOL_CODES = 3'd0;
  localparam logic [2:0] REG_MOTOR_RUN      = 3'd1;
  localparam logic [2:0] REG_DOOR_OPEN      = 3'd2;
  localparam logic [2:0] REG_ALARM          = 3'd3;
  localparam logic [2:0] REG_ATTEMPT_LIMIT  = 3'd4;

  localparam logic [63:0] PROTOCOL_CODES_RST = 64'h0807_0605_0403_0201;
  localparam logic [15:0] MOTOR_RUN_RST      = 16'd15;
  localparam logic [15:0] DOOR_OPEN_RST      = 16'd3;
  localparam logic [15:0] ALARM_RST          = 16'd60;
  localparam logic [7:0]  ATTEMPT_LIMIT_RST  = 8'd3;

  typedef enum logic [4:0] {
    A_NOP           = 5'd0,
    A_ACCEPT        = 5'd1,
    A_SEC_INC       = 5'd2,
    A_WAIT_HIT      = 5'd3,
    A_STORE_ENTRY   = 5'd4,
    A_STORE_CONFIRM = 5'd5,
    A_CMP_ENROLL    = 5'd6,
    A_CMP_CMD       = 5'd7,
    A_SET_IDLE      = 5'd8,
    A_SET_WAIT1     = 5'd9,
    A_SET_CODE      = 5'd10,
    A_OPEN          = 5'd11,
    A_WC_INC        = 5'd12,
    A_ALARM         = 5'd13,
    A_SETTLE        = 5'd14,
    A_EMIT0         = 5'd15,
    A_EMIT1         = 5'd16
  } act_t;

  typedef enum logic [4:0] {
    C_NEVER       = 5'd0,
    C_ALWAYS      = 5'd1,
    C_NO_ITEM     = 5'd2,
    C_TICK        = 5'd3,
    C_TIMED       = 5'd4,
    C_PH_WAIT     = 5'd5,
    C_PH_ENTRY    = 5'd6,
    C_PH_CONFIRM  = 5'd7,
    C_PH_IDLE     = 5'd8,
    C_PH_CMD      = 5'd9,
    C_BYTE_READY  = 5'd10,
    C_BYTE_PLUS   = 5'd11,
    C_BYTE_CHANGE = 5'd12,
    C_IDX_LAST    = 5'd13,
    C_CI_MORE     = 5'd14,
    C_NEQ         = 5'd15,
    C_WC_ALARM    = 5'd16,
    C_SETTLE      = 5'd17,
    C_OUT_BUSY    = 5'd18,
    C_ONE_TX      = 5'd19
  } cond_t;

  localparam int UPC_W = 6;

  typedef struct packed {
    act_t             act;
    logic             send;
    logic [2:0]       key;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // program addresses
  localparam logic [UPC_W-1:0] U_FETCH      = 6'd0;
  localparam logic [UPC_W-1:0] U_DISP_TICK  = 6'd1;
  localparam logic [UPC_W-1:0] U_DISP_TIMED = 6'd2;
  localparam logic [UPC_W-1:0] U_DISP_WAIT  = 6'd3;
  localparam logic [UPC_W-1:0] U_DISP_ENTRY = 6'd4;
  localparam logic [UPC_W-1:0] U_DISP_CONF  = 6'd5;
  localparam logic [UPC_W-1:0] U_DISP_IDLE  = 6'd6;
  localparam logic [UPC_W-1:0] U_DISP_CMD   = 6'd7;
  localparam logic [UPC_W-1:0] U_DISP_NONE  = 6'd8;
  localparam logic [UPC_W-1:0] U_TICK       = 6'd9;
  localparam logic [UPC_W-1:0] U_WAIT       = 6'd10;
  localparam logic [UPC_W-1:0] U_WAIT_MISS  = 6'd11;
  localparam logic [UPC_W-1:0] U_WAIT_HIT   = 6'd12;
  localparam logic [UPC_W-1:0] U_ENTRY      = 6'd13;
  localparam logic [UPC_W-1:0] U_CONF       = 6'd14;
  localparam logic [UPC_W-1:0] U_CONF_MORE  = 6'd15;
  localparam logic [UPC_W-1:0] U_CONF_DONE  = 6'd16;
  localparam logic [UPC_W-1:0] U_CMP_EN     = 6'd17;
  localparam logic [UPC_W-1:0] U_VERDICT    = 6'd18;
  localparam logic [UPC_W-1:0] U_MATCHED    = 6'd19;
  localparam logic [UPC_W-1:0] U_MISMATCH   = 6'd20;
  localparam logic [UPC_W-1:0] U_IDLE       = 6'd21;
  localparam logic [UPC_W-1:0] U_IDLE_MISS  = 6'd22;
  localparam logic [UPC_W-1:0] U_IDLE_HIT   = 6'd23;
  localparam logic [UPC_W-1:0] U_CMP_CMD    = 6'd24;
  localparam logic [UPC_W-1:0] U_CMD_PLUS   = 6'd25;
  localparam logic [UPC_W-1:0] U_CMD_CHANGE = 6'd26;
  localparam logic [UPC_W-1:0] U_CMD_DROP   = 6'd27;
  localparam logic [UPC_W-1:0] U_PLUS       = 6'd28;
  localparam logic [UPC_W-1:0] U_UNLOCK     = 6'd29;
  localparam logic [UPC_W-1:0] U_CHANGE     = 6'd30;
  localparam logic [UPC_W-1:0] U_CHANGING   = 6'd31;
  localparam logic [UPC_W-1:0] U_WRONG      = 6'd32;
  localparam logic [UPC_W-1:0] U_WRONG_TEST = 6'd33;
  localparam logic [UPC_W-1:0] U_WRONG_IDLE = 6'd34;
  localparam logic [UPC_W-1:0] U_ALARM      = 6'd35;
  localparam logic [UPC_W-1:0] U_SETTLE     = 6'd36;
  localparam logic [UPC_W-1:0] U_EMIT0      = 6'd37;
  localparam logic [UPC_W-1:0] U_EMIT_TEST  = 6'd38;
  localparam logic [UPC_W-1:0] U_EMIT1      = 6'd39;
  localparam logic [UPC_W-1:0] U_EMIT_DONE  = 6'd40;

  function automatic uword_t uw(act_t a, logic s, logic [2:0] k, cond_t c,
                                logic [UPC_W-1:0] t);
    uword_t w;
    w.act    = a;
    w.send   = s;
    w.key    = k;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Control store: act, send, key, jump condition, jump target.
  // Falls through to the next address when the condition is false.
  function automatic uword_t ucode(logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      U_FETCH:      w = uw(A_ACCEPT, 1'b0, KEY_READY_SEND, C_NO_ITEM, U_FETCH);
      U_DISP_TICK:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_TICK, U_TICK);
      U_DISP_TIMED: w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_TIMED, U_SETTLE);
      U_DISP_WAIT:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_PH_WAIT, U_WAIT);
      U_DISP_ENTRY: w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_PH_ENTRY, U_ENTRY);
      U_DISP_CONF:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_PH_CONFIRM, U_CONF);
      U_DISP_IDLE:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_PH_IDLE, U_IDLE);
      U_DISP_CMD:   w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_PH_CMD, U_CMP_CMD);
      U_DISP_NONE:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_TICK:       w = uw(A_SEC_INC, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_WAIT:       w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_BYTE_READY, U_WAIT_HIT);
      U_WAIT_MISS:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_WAIT_HIT:   w = uw(A_WAIT_HIT, 1'b1, KEY_READY_RECV, C_ALWAYS, U_SETTLE);
      U_ENTRY:      w = uw(A_STORE_ENTRY, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_CONF:       w = uw(A_STORE_CONFIRM, 1'b0, KEY_READY_SEND, C_IDX_LAST,
                           U_CONF_DONE);
      U_CONF_MORE:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_CONF_DONE:  w = uw(A_NOP, 1'b1, KEY_READY_SEND, C_NEVER, U_FETCH);
      U_CMP_EN:     w = uw(A_CMP_ENROLL, 1'b0, KEY_READY_SEND, C_CI_MORE, U_CMP_EN);
      U_VERDICT:    w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_NEQ, U_MISMATCH);
      U_MATCHED:    w = uw(A_SET_IDLE, 1'b1, KEY_MATCHED, C_ALWAYS, U_SETTLE);
      U_MISMATCH:   w = uw(A_SET_WAIT1, 1'b1, KEY_MISMATCHED, C_ALWAYS, U_SETTLE);
      U_IDLE:       w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_BYTE_READY, U_IDLE_HIT);
      U_IDLE_MISS:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_IDLE_HIT:   w = uw(A_SET_CODE, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_CMP_CMD:    w = uw(A_CMP_CMD, 1'b0, KEY_READY_SEND, C_CI_MORE, U_CMP_CMD);
      U_CMD_PLUS:   w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_BYTE_PLUS, U_PLUS);
      U_CMD_CHANGE: w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_BYTE_CHANGE, U_CHANGE);
      U_CMD_DROP:   w = uw(A_SET_IDLE, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_PLUS:       w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_NEQ, U_WRONG);
      U_UNLOCK:     w = uw(A_OPEN, 1'b1, KEY_UNLOCKING, C_ALWAYS, U_SETTLE);
      U_CHANGE:     w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_NEQ, U_WRONG);
      U_CHANGING:   w = uw(A_SET_WAIT1, 1'b1, KEY_CHANGING, C_ALWAYS, U_SETTLE);
      U_WRONG:      w = uw(A_WC_INC, 1'b1, KEY_WRONG, C_NEVER, U_FETCH);
      U_WRONG_TEST: w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_WC_ALARM, U_ALARM);
      U_WRONG_IDLE: w = uw(A_SET_IDLE, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_ALARM:      w = uw(A_ALARM, 1'b0, KEY_READY_SEND, C_ALWAYS, U_SETTLE);
      U_SETTLE:     w = uw(A_SETTLE, 1'b0, KEY_READY_SEND, C_SETTLE, U_SETTLE);
      U_EMIT0:      w = uw(A_EMIT0, 1'b0, KEY_READY_SEND, C_OUT_BUSY, U_EMIT0);
      U_EMIT_TEST:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_ONE_TX, U_FETCH);
      U_EMIT1:      w = uw(A_EMIT1, 1'b0, KEY_READY_SEND, C_OUT_BUSY, U_EMIT1);
      U_EMIT_DONE:  w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_ALWAYS, U_FETCH);
      default:      w = uw(A_NOP, 1'b0, KEY_READY_SEND, C_ALWAYS, U_FETCH);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/password_door_lock_controller.sv
// Combination lock controller: microcoded sequencer and its datapath.
// Depends on pdlc_pkg (payload types, codes, control store).

// Takes serial bytes and one-second ticks (op 0 / op 1) one transfer at a time
// and answers each with one result, or two when an enrollment ends (ready-send,
// then matched or mismatched); every result carries the motor and buzzer state
// as it stands after the item, and last marks the final one. The work is run by
// a step counter over a read-only control store, one step per cycle. A code is
// compared one code byte per cycle; timed phases that end are settled before
// the result is emitted, and the emit step holds while the output stalls.
// in_stall is low only while the sequencer waits at its fetch step; a result
// waits in the output register while the next item is taken.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// (cfg_ready is always high); indexes beyond the register list are dropped.
module password_door_lock_controller import pdlc_pkg::*; #(
  parameter int CODE_LENGTH = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CODE_LENGTH - 1);

  // configuration
  logic [63:0] protocol_codes;
  logic [15:0] motor_run_seconds;
  logic [15:0] door_open_seconds;
  logic [15:0] alarm_seconds;
  logic [7:0]  attempt_limit;

  // sequencer
  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  uword_t           uword;
  logic             cond_true;

  // datapath
  in_t           item;
  phase_t        phase;
  logic [IW-1:0] byte_index;
  logic [IW-1:0] ci;
  logic          neq;
  logic [7:0]    entry_buf   [CODE_LENGTH];
  logic [7:0]    confirm_buf [CODE_LENGTH];
  logic [7:0]    stored_code [CODE_LENGTH];
  logic [7:0]    wrong_count;
  logic [15:0]   seconds_count;
  logic [1:0]    motor_state;
  logic          buzzer_state;
  logic [7:0]    tx0;
  logic [7:0]    tx1;
  logic [1:0]    tx_count;

  logic       in_fire;
  logic       out_take;
  logic       out_busy;
  logic       timed;
  logic       settle_hit;
  logic [7:0] proto_byte;
  logic [7:0] ready_code;
  logic [7:0] change_code;

  assign cfg_ready = 1'b1;
  assign in_stall  = (upc != U_FETCH);
  assign in_fire   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_busy  = out_valid && out_stall;

  assign uword       = ucode(upc);
  assign proto_byte  = protocol_codes[{uword.key, 3'b000} +: 8];
  assign ready_code  = protocol_codes[{KEY_READY_SEND, 3'b000} +: 8];
  assign change_code = protocol_codes[{KEY_CHANGE, 3'b000} +: 8];

  assign timed = (phase == PH_RUN_CW) || (phase == PH_OPEN) ||
                 (phase == PH_RUN_CCW) || (phase == PH_ALARM);

  always_comb begin
    case (phase)
      PH_RUN_CW:  settle_hit = (seconds_count >= motor_run_seconds);
      PH_OPEN:    settle_hit = (seconds_count >= door_open_seconds);
      PH_RUN_CCW: settle_hit = (seconds_count >= motor_run_seconds);
      PH_ALARM:   settle_hit = (seconds_count >= alarm_seconds);
      default:    settle_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (uword.cond)
      C_NEVER:       cond_true = 1'b0;
      C_ALWAYS:      cond_true = 1'b1;
      C_NO_ITEM:     cond_true = !in_fire;
      C_TICK:        cond_true = (item.op == OP_TICK);
      C_TIMED:       cond_true = timed;
      C_PH_WAIT:     cond_true = (phase == PH_EN_WAIT1) || (phase == PH_EN_WAIT2);
      C_PH_ENTRY:    cond_true = (phase == PH_EN_CODE1) || (phase == PH_CODE);
      C_PH_CONFIRM:  cond_true = (phase == PH_EN_CODE2);
      C_PH_IDLE:     cond_true = (phase == PH_IDLE);
      C_PH_CMD:      cond_true = (phase == PH_CMD);
      C_BYTE_READY:  cond_true = (item.rx_byte == ready_code);
      C_BYTE_PLUS:   cond_true = (item.rx_byte == CHAR_PLUS);
      C_BYTE_CHANGE: cond_true = (item.rx_byte == change_code);
      C_IDX_LAST:    cond_true = (byte_index == LAST_IDX);
      C_CI_MORE:     cond_true = (ci != LAST_IDX);
      C_NEQ:         cond_true = neq;
      C_WC_ALARM:    cond_true = (wrong_count >= attempt_limit);
      C_SETTLE:      cond_true = settle_hit;
      C_OUT_BUSY:    cond_true = out_busy;
      C_ONE_TX:      cond_true = (tx_count <= 2'd1);
      default:       cond_true = 1'b0;
    endcase
  end

  assign upc_next = cond_true ? uword.target : upc + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_codes    <= PROTOCOL_CODES_RST;
      motor_run_seconds <= MOTOR_RUN_RST;
      door_open_seconds <= DOOR_OPEN_RST;
      alarm_seconds     <= ALARM_RST;
      attempt_limit     <= ATTEMPT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROTOCOL_CODES: protocol_codes    <= cfg_data;
        REG_MOTOR_RUN:      motor_run_seconds <= cfg_data[15:0];
        REG_DOOR_OPEN:      door_open_seconds <= cfg_data[15:0];
        REG_ALARM:          alarm_seconds     <= cfg_data[15:0];
        REG_ATTEMPT_LIMIT:  attempt_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // code stores: written at byte_index, read at the compare index
  always_ff @(posedge clk) begin
    case (uword.act)
      A_STORE_ENTRY:   entry_buf[byte_index]   <= item.rx_byte;
      A_STORE_CONFIRM: confirm_buf[byte_index] <= item.rx_byte;
      // copied while comparing; a mismatch sends enrollment back to the start,
      // so the stored code is never read before a full matched copy
      A_CMP_ENROLL:    stored_code[ci]         <= entry_buf[ci];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uword.act == A_ACCEPT && in_fire) begin
      item <= in_data;
    end
    if (uword.send) begin
      if (tx_count == 2'd0) begin
        tx0 <= proto_byte;
      end else begin
        tx1 <= proto_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_EN_WAIT1;
      byte_index    <= '0;
      ci            <= '0;
      neq           <= 1'b0;
      wrong_count   <= '0;
      seconds_count <= '0;
      motor_state   <= MOTOR_STOP;
      buzzer_state  <= 1'b0;
      tx_count      <= '0;
    end else begin
      if (uword.send) begin
        tx_count <= tx_count + 2'd1;
      end
      case (uword.act)
        A_ACCEPT: begin
          if (in_fire) begin
            ci       <= '0;
            neq      <= 1'b0;
            tx_count <= '0;
          end
        end
        A_SEC_INC: begin
          if (timed && seconds_count != 16'hFFFF) begin
            seconds_count <= seconds_count + 16'd1;
          end
        end
        A_WAIT_HIT: begin
          phase      <= (phase == PH_EN_WAIT1) ? PH_EN_CODE1 : PH_EN_CODE2;
          byte_index <= '0;
        end
        A_STORE_ENTRY: begin
          if (byte_index == LAST_IDX) begin
            byte_index <= '0;
            phase      <= (phase == PH_EN_CODE1) ? PH_EN_WAIT2 : PH_CMD;
          end else begin
            byte_index <= byte_index + 1'b1;
          end
        end
        A_STORE_CONFIRM: begin
          byte_index <= (byte_index == LAST_IDX) ? '0 : byte_index + 1'b1;
        end
        A_CMP_ENROLL: begin
          neq <= neq | (entry_buf[ci] != confirm_buf[ci]);
          ci  <= (ci == LAST_IDX) ? '0 : ci + 1'b1;
        end
        A_CMP_CMD: begin
          neq <= neq | (stored_code[ci] != entry_buf[ci]);
          ci  <= (ci == LAST_IDX) ? '0 : ci + 1'b1;
        end
        A_SET_IDLE: phase <= PH_IDLE;
        A_SET_WAIT1: begin
          phase      <= PH_EN_WAIT1;
          byte_index <= '0;
        end
        A_SET_CODE: begin
          phase      <= PH_CODE;
          byte_index <= '0;
        end
        A_OPEN: begin
          phase         <= PH_RUN_CW;
          motor_state   <= MOTOR_CW;
          seconds_count <= '0;
        end
        A_WC_INC: begin
          if (wrong_count != 8'hFF) begin
            wrong_count <= wrong_count + 8'd1;
          end
        end
        A_ALARM: begin
          phase         <= PH_ALARM;
          buzzer_state  <= 1'b1;
          seconds_count <= '0;
        end
        A_SETTLE: begin
          if (settle_hit) begin
            case (phase)
              PH_RUN_CW: begin
                phase         <= PH_OPEN;
                seconds_count <= '0;
                motor_state   <= MOTOR_STOP;
              end
              PH_OPEN: begin
                phase         <= PH_RUN_CCW;
                seconds_count <= '0;
                motor_state   <= MOTOR_CCW;
              end
              PH_RUN_CCW: begin
                phase       <= PH_IDLE;
                motor_state <= MOTOR_STOP;
              end
              PH_ALARM: begin
                phase        <= PH_IDLE;
                buzzer_state <= 1'b0;
                wrong_count  <= '0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uword.act == A_EMIT0 || uword.act == A_EMIT1) && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_busy) begin
      if (uword.act == A_EMIT0) begin
        out_data.tx_valid    <= (tx_count != 2'd0);
        out_data.tx_byte     <= (tx_count != 2'd0) ? tx0 : 8'd0;
        out_data.motor_drive <= motor_state;
        out_data.buzzer_on   <= buzzer_state;
        out_data.last        <= (tx_count <= 2'd1);
      end else if (uword.act == A_EMIT1) begin
        out_data.tx_valid    <= 1'b1;
        out_data.tx_byte     <= tx1;
        out_data.motor_drive <= motor_state;
        out_data.buzzer_on   <= buzzer_state;
        out_data.last        <= 1'b1;
      end
    end
  end

  // checks
  a_buzzer_in_alarm: assert property (@(posedge clk) disable iff (rst)
    buzzer_state |-> (phase == PH_ALARM))
    else $error("buzzer on outside the alarm phase");

  a_motor_in_run: assert property (@(posedge clk) disable iff (rst)
    (motor_state != MOTOR_STOP) |-> ((phase == PH_RUN_CW) || (phase == PH_RUN_CCW)))
    else $error("motor driven outside a run phase");

  a_tx_count: assert property (@(posedge clk) disable iff (rst)
    tx_count <= 2'd2)
    else $error("more than two bytes queued for one item");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (byte_index <= LAST_IDX) && (ci <= LAST_IDX))
    else $error("code index out of range");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_stall)
    else $error("second item taken while one is in work");

endmodule
